@@ hw/rtl/keyframe_linear_interpolator_assert.svh @@
// Assertion macros for the keyframe interpolator RTL.
// Depends on nothing; included by the modules that check themselves.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define KLI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define KLI_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define KLI_ASSERT(label, clk, rst_n, prop)
`define KLI_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ hw/rtl/kli_pkg.sv @@
// Package for the keyframe interpolator: request/result structs, codes, control structs.
// Depends on nothing.
package kli_pkg;
  localparam int MAX_KEYS = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_INTERP_MODE = 2'd1;
  localparam logic [1:0] REG_COMP_COUNT = 2'd2;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef struct packed {
    logic               command;
    logic [5:0]         key_slot;
    logic [31:0]        time_req;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_a;
    logic signed [31:0] result_b;
    logic signed [31:0] result_c;
    logic signed [31:0] result_d;
    logic [5:0]         lower_key;
    logic [5:0]         upper_key;
    logic [16:0]        upper_weight;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic wr_key;     // store keyframe
    logic rd_time;    // read time at scan index
    logic scan_init;
    logic scan_step;  // compare time, advance
    logic rd_vals;    // read lower/upper values
    logic div_init;
    logic div_step;
    logic mul_comp;   // mix in one value read
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
    logic wr_busy;    // value sweep of a write still running
    logic scan_done;
    logic div_done;
    logic comp_done;
  } dp_sts_t;
endpackage

@@ hw/rtl/kli_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/kli_ctrl.sv @@
// Controller state machine for the keyframe interpolator.
// Depends on kli_pkg and the assertion header.
`include "keyframe_linear_interpolator_assert.svh"
module kli_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  kli_pkg::dp_sts_t sts,
  output logic             busy,
  output kli_pkg::dp_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WRV, S_RDT, S_WAITT, S_SCAN, S_DIVI, S_DIV, S_RDV, S_WAITV, S_MUL,
    S_EMIT
  } state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE:   if (start) begin cmd.load = 1'b1; state_nxt = S_DECODE; end
      S_DECODE: begin
        if (sts.is_query) begin cmd.scan_init = 1'b1; state_nxt = S_RDT; end
        else begin cmd.wr_key = 1'b1; state_nxt = S_WRV; end
      end
      // hold off new requests until all values are stored
      S_WRV:    if (!sts.wr_busy) state_nxt = S_IDLE;
      S_RDT:    begin cmd.rd_time = 1'b1; state_nxt = S_WAITT; end
      S_WAITT:  state_nxt = S_SCAN;
      S_SCAN:   begin
        cmd.scan_step = 1'b1;
        state_nxt = sts.scan_done ? S_DIVI : S_RDT;
      end
      S_DIVI:   begin cmd.div_init = 1'b1; state_nxt = S_DIV; end
      S_DIV:    begin cmd.div_step = 1'b1; if (sts.div_done) state_nxt = S_RDV; end
      S_RDV:    begin cmd.rd_vals = 1'b1; state_nxt = S_WAITV; end
      S_WAITV:  state_nxt = S_MUL;
      S_MUL:    begin
        cmd.mul_comp = 1'b1;
        state_nxt = sts.comp_done ? S_EMIT : S_RDV;
      end
      S_EMIT:   begin cmd.emit = 1'b1; state_nxt = S_IDLE; end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
  assign busy = (state_r != S_IDLE);

  `KLI_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `KLI_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.load, cmd.emit, cmd.wr_key, cmd.div_step}))
  `KLI_ASSERT_NEXT(a_emit_idle, clk, rst_n, cmd.emit, !busy)
endmodule

@@ hw/rtl/kli_dp.sv @@
// Datapath for the keyframe interpolator: key stores, scan, divider, mixer.
// Depends on kli_pkg, kli_ram and the assertion header.
`include "keyframe_linear_interpolator_assert.svh"
module kli_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  kli_pkg::in_item_t  req,
  input  kli_pkg::dp_cmd_t   cmd,
  input  logic [6:0]         key_count,
  input  logic               interp_mode,
  input  logic [2:0]         component_count,
  output kli_pkg::dp_sts_t   sts,
  output logic               out_strobe,
  output kli_pkg::out_item_t out_item
);
  localparam int MAX_KEYS = kli_pkg::MAX_KEYS;
  localparam int MAX_COMPONENTS = kli_pkg::MAX_COMPONENTS;
  localparam int KW = $clog2(MAX_KEYS);
  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int VD = MAX_KEYS * MAX_COMPONENTS;
  localparam int VW = $clog2(VD);

  kli_pkg::in_item_t req_r;
  logic [KW:0] last_r, k_r, k_nxt;          // scan index
  logic [KW-1:0] lower_r, upper_r;
  logic [31:0] t_r, t0_r;                    // clamped time, lower key time
  logic [31:0] tr_rdata, vr_rdata;
  logic [KW-1:0] t_raddr, wr_slot;
  logic slot_ok;
  logic [2:0] comps;
  logic [KW:0] n;
  logic [1:0] wcnt_r;                        // write sweep over components
  logic wr_act_r;
  logic [VW-1:0] v_waddr, v_raddr;
  logic [31:0] v_wdata;
  logic [CW-1:0] comp_r;
  logic side_r;                              // 0 lower value, 1 upper value
  logic [47:0] rem_r;
  logic [31:0] den_r;
  logic [16:0] q_r, w_r;
  logic [4:0] dcnt_r;
  logic div_en_r;
  logic signed [31:0] res_r [4];
  logic [49:0] dsub;

  // clamp counts
  always_comb begin
    n = (key_count == 7'd0) ? (KW+1)'(1) :
        ((32'(key_count) > MAX_KEYS) ? (KW+1)'(MAX_KEYS) : (KW+1)'(key_count));
    comps = (component_count == 3'd0) ? 3'd1 :
            ((32'(component_count) > MAX_COMPONENTS) ? 3'(MAX_COMPONENTS) : component_count);
  end

  assign slot_ok = (32'(req_r.key_slot) < MAX_KEYS);
  assign wr_slot = KW'(req_r.key_slot);
  assign sts.is_query = req_r.command == kli_pkg::CMD_QUERY;
  assign sts.wr_busy = wr_act_r;

  // time store
  assign t_raddr = k_r[KW-1:0];
  kli_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
    .clk, .we(cmd.wr_key && slot_ok), .waddr(wr_slot), .wdata(req_r.time_req),
    .raddr(t_raddr), .rdata(tr_rdata));

  // value store, written one component per cycle after the time
  always_comb begin
    case (wcnt_r)
      2'd0: v_wdata = req_r.value_a;
      2'd1: v_wdata = req_r.value_b;
      2'd2: v_wdata = req_r.value_c;
      default: v_wdata = req_r.value_d;
    endcase
  end
  assign v_waddr = VW'({wr_slot, CW'(wcnt_r)});
  assign v_raddr = VW'({(side_r ? upper_r : lower_r), comp_r});
  kli_ram #(.WIDTH(32), .DEPTH(VD)) u_vals (
    .clk, .we(wr_act_r && slot_ok), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(vr_rdata));

  // scan state: k_r walks 0,last,1,2...
  logic [1:0] ph_r;  // 0 first key, 1 last key, 2 walking
  logic [31:0] tfirst_r;
  logic below_r;     // query time below the first key
  logic sdone;
  logic [KW-1:0] lo_sel;
  logic [31:0] t0_sel;
  always_comb begin
    sdone = 1'b0;
    k_nxt = k_r;
    lo_sel = lower_r;
    t0_sel = t0_r;
    if (ph_r == 2'd0) begin
      k_nxt = last_r;
      t0_sel = tr_rdata;
      if (last_r == '0) begin sdone = 1'b1; lo_sel = '0; end
    end else if (ph_r == 2'd1) begin
      t0_sel = tfirst_r;
      if (below_r) begin sdone = 1'b1; lo_sel = '0; end
      else if (t_r >= tr_rdata) begin
        sdone = 1'b1; lo_sel = last_r[KW-1:0]; t0_sel = tr_rdata;
      end
      else if (last_r == (KW+1)'(1)) begin sdone = 1'b1; lo_sel = '0; end
      else k_nxt = (KW+1)'(1);
    end else begin
      if (k_r < last_r && t_r >= tr_rdata) begin k_nxt = k_r + 1'b1; t0_sel = tr_rdata; end
      else begin sdone = 1'b1; lo_sel = KW'(k_r - 1'b1); end
    end
  end
  assign sts.scan_done = sdone;

  // divider: restoring, one quotient bit per cycle (17 bits)
  assign dsub = {2'b0, rem_r} - {18'd0, den_r};
  assign sts.div_done = (dcnt_r == 5'd0);

  // mixer: two multiplies per component over two reads in linear mode, one read in step mode
  logic signed [49:0] prod;
  logic signed [17:0] wmul;
  logic signed [31:0] mixed;
  logic signed [49:0] acc_r;
  logic signed [49:0] sum;
  assign wmul = side_r ? $signed({1'b0, w_r}) : $signed({1'b0, kli_pkg::WEIGHT_ONE - w_r});
  assign prod = $signed(vr_rdata) * wmul;
  assign sum = acc_r + prod;
  assign mixed = 32'((sum + 50'sd32768) >>> 16);
  assign sts.comp_done = side_r && (32'(comp_r) == MAX_COMPONENTS - 1 || comp_r == CW'(comps - 1'b1))
                         || (!interp_mode && 32'(comp_r) + 1 >= 32'(comps));

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
    if (!rst_n) wr_act_r <= 1'b0;
    else if (cmd.wr_key) wr_act_r <= 1'b1;
    else if (wcnt_r == 2'(MAX_COMPONENTS - 1)) wr_act_r <= 1'b0;
    if (cmd.wr_key) wcnt_r <= 2'd0;
    else if (wr_act_r) wcnt_r <= wcnt_r + 2'd1;

    if (cmd.scan_init) begin
      k_r <= '0; ph_r <= 2'd0; last_r <= n - 1'b1; t_r <= req_r.time_req;
    end
    if (cmd.scan_step) begin
      k_r <= k_nxt;
      if (ph_r == 2'd0) begin
        tfirst_r <= tr_rdata; ph_r <= 2'd1;
        below_r <= req_r.time_req < tr_rdata;
        if (req_r.time_req < tr_rdata || last_r == '0) t_r <= tr_rdata;
      end else ph_r <= 2'd2;
      if (ph_r == 2'd1 && !below_r && t_r >= tr_rdata) t_r <= tr_rdata;
      if (sdone) lower_r <= lo_sel;
      // remember lower key time
      t0_r <= t0_sel;
    end
    // divider setup reads t1 from upper key, computed after scan
    if (cmd.div_init) begin
      logic [KW-1:0] up;
      up = (KW+1)'(lower_r) + 1'b1 < last_r ? lower_r + 1'b1 : last_r[KW-1:0];
      upper_r <= interp_mode ? up : lower_r;
      k_r <= (KW+1)'(up);
      dcnt_r <= 5'd20;
      div_en_r <= 1'b0;
      q_r <= '0;
      comp_r <= '0;
      side_r <= 1'b0;
      acc_r <= '0;
    end
    if (cmd.div_step && dcnt_r != 5'd0) begin
      dcnt_r <= dcnt_r - 5'd1;
      if (dcnt_r == 5'd18) begin
        div_en_r <= interp_mode && (upper_r != lower_r) && (tr_rdata > t0_r) && (t_r >= t0_r);
        den_r <= tr_rdata - t0_r;
        rem_r <= 48'(t_r - t0_r);
      end else if (dcnt_r <= 5'd17) begin
        if (!dsub[49]) begin rem_r <= {dsub[46:0], 1'b0}; q_r <= {q_r[15:0], 1'b1}; end
        else begin rem_r <= {rem_r[46:0], 1'b0}; q_r <= {q_r[15:0], 1'b0}; end
      end
      // last quotient bit taken straight from this step
      if (dcnt_r == 5'd1) w_r <= div_en_r ? {q_r[15:0], !dsub[49]} : 17'd0;
    end
    if (cmd.mul_comp) begin
      if (!interp_mode) begin
        res_r[comp_r] <= $signed(vr_rdata);
        comp_r <= comp_r + 1'b1;
      end else if (!side_r) begin
        acc_r <= prod; side_r <= 1'b1;
      end else begin
        res_r[comp_r] <= mixed; side_r <= 1'b0; acc_r <= '0;
        comp_r <= comp_r + 1'b1;
      end
    end
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= cmd.emit;
    if (cmd.emit) begin
      out_item.result_a <= res_r[0];
      out_item.result_b <= (comps > 3'd1) ? res_r[1] : '0;
      out_item.result_c <= (comps > 3'd2) ? res_r[2] : '0;
      out_item.result_d <= (comps > 3'd3) ? res_r[3] : '0;
      out_item.lower_key <= 6'(lower_r);
      out_item.upper_key <= 6'(upper_r);
      out_item.upper_weight <= w_r;
    end
  end

  `KLI_ASSERT(a_wt_range, clk, rst_n, out_strobe |-> out_item.upper_weight <= kli_pkg::WEIGHT_ONE)
  `KLI_ASSERT_NEXT(a_emit_strobe, clk, rst_n, cmd.emit, out_strobe)
  `KLI_ASSERT(a_step_zero, clk, rst_n,
    (out_strobe && out_item.upper_key == out_item.lower_key) |-> out_item.upper_weight == 17'd0)
endmodule

@@ hw/rtl/keyframe_linear_interpolator.sv @@
// Keyframe interpolator top level: config registers, controller and datapath.
// Depends on kli_pkg, kli_ctrl, kli_dp and the assertion header.
//
// Usage: raise start with in_item; the request is taken when busy is low.
// A write request (command 0) stores a keyframe and holds busy until all of
// its values are stored, no result.
// A query request (command 1) finds the bracketing keys by a serial scan of
// the time memory (1 to MAX_KEYS+1 reads), divides for the Q1.16 weight in a
// 17-step restoring divider, then mixes each component with one multiplier
// over the value memory (two reads per component in linear mode, one in step
// mode). A query holds busy through the scan, the divide and the mix; the
// result is strobed in the cycle after busy falls, and the next request may
// be taken in that same cycle.
// The result appears for one cycle with out_strobe; the receiver cannot stall.
// The user writes config through cfg_valid/cfg_ready with cfg_index/cfg_data
// only while idle; the block does not enforce it. Reset clears control and
// sets config to 1 key, linear mode, 4 components; key memories are undefined until written.
`include "keyframe_linear_interpolator_assert.svh"
module keyframe_linear_interpolator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  kli_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output kli_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [6:0] key_count_r;
  logic       interp_mode_r;
  logic [2:0] comp_count_r;
  kli_pkg::dp_cmd_t cmd;
  kli_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;
  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= 7'd1; interp_mode_r <= 1'b1; comp_count_r <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kli_pkg::REG_KEY_COUNT:   key_count_r <= cfg_data[6:0];
        kli_pkg::REG_INTERP_MODE: interp_mode_r <= cfg_data[0];
        kli_pkg::REG_COMP_COUNT:  comp_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  kli_ctrl u_ctrl (.clk, .rst_n, .start, .sts, .busy, .cmd);
  kli_dp u_dp (
    .clk, .rst_n, .req(in_item), .cmd, .key_count(key_count_r),
    .interp_mode(interp_mode_r), .component_count(comp_count_r),
    .sts, .out_strobe, .out_item);

  `KLI_ASSERT(a_no_strobe_idle, clk, rst_n, out_strobe |-> !busy)
  `KLI_ASSERT_NEXT(a_cfg_hold, clk, rst_n, busy && !cfg_valid, $stable(key_count_r))
  `KLI_ASSERT_NEXT(a_kc_write, clk, rst_n, cfg_valid && cfg_index == kli_pkg::REG_KEY_COUNT,
    key_count_r == $past(cfg_data[6:0]))
endmodule
